// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tiec_pkg.sv =====
package tiec_pkg;

   localparam int NUM_DECLS = 17;
   localparam logic [4:0] NO_SLOT = 5'd17;

   localparam logic [15:0] TYPE_SHORT  = 16'd3;
   localparam logic [15:0] TYPE_LONG   = 16'd4;
   localparam logic [15:0] TYPE_SSHORT = 16'd8;
   localparam logic [15:0] TYPE_SLONG  = 16'd9;
   localparam logic [15:0] TYPE_LAST   = 16'd12;

   typedef enum logic [2:0] {
      ST_OK,
      ST_UNSUPPORTED,
      ST_ZERO_COUNT,
      ST_PAST_END,
      ST_OUT_OF_ORDER,
      ST_UNKNOWN_TAG,
      ST_WRONG_TYPE,
      ST_WRONG_COUNT
   } status_type;

   typedef struct packed {
      logic        big_endian;
      logic [31:0] file_size;
   } cfg_type;

   typedef struct packed {
      logic        have;
      logic [15:0] tag;
   } hist_type;

   typedef struct packed {
      logic        commit;
      logic        first;
      logic        record;
      logic [15:0] tag;
   } hist_upd_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] tag;
      logic [15:0] entry_type;
      logic [31:0] count;
      logic        is_reference;
      logic [31:0] value_word;
      logic [4:0]  table_slot;
   } result_type;

   // Declared tags, the allowed type mask (bit n for type n), and whether
   // the count must be exactly one.
   localparam logic [15:0] DECL_TAG [NUM_DECLS] = '{
      16'd256,   16'd257,   16'd258,   16'd269,   16'd270,   16'd271,
      16'd272,   16'd277,   16'd305,   16'd315,   16'd33434, 16'd33437,
      16'd34665, 16'd34853, 16'd34855, 16'd37386, 16'd41989
   };

   localparam logic [15:0] DECL_TYPEMASK [NUM_DECLS] = '{
      16'h0018, 16'h0018, 16'h0008, 16'h0004, 16'h0004, 16'h0004,
      16'h0004, 16'h0008, 16'h0004, 16'h0004, 16'h0020, 16'h0020,
      16'h0010, 16'h0010, 16'h0008, 16'h0020, 16'h0008
   };

   localparam logic DECL_COUNT_ONE [NUM_DECLS] = '{
      1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
      1'b1, 1'b1, 1'b0, 1'b1, 1'b1
   };

   function automatic logic [15:0] swap16(input logic [15:0] h);
      return {h[7:0], h[15:8]};
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

// ===== hw/rtl/tiff_ifd_entry_checker_top.sv =====
// TIFF directory entry checker.
// Input channel (req_*): one 12-byte directory entry per transfer as three raw
// 32-bit words plus a first-of-directory flag. Output channel (rsp_*): one
// result per entry with status, decoded tag, type, count, reference flag,
// value word and table slot, in input order.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. An accepted entry is held in the input register, checked in
// a single pass and moves into the result register once that register is
// empty or being taken; the result is offered on the output channel from there.
// Throughput is one entry per cycle while the receiver does not stall; the
// ordering check reads the last-tag register, which an entry with a
// supported type, a nonzero count, in range and in order updates as it moves
// into the result register; a rejected first entry of a directory clears it.
// When the receiver stalls, the result register holds; the input register
// still fills, and req_stall rises only once both registers are full.
// The APB port sets byte order (address 0) and file size (address 4); write
// them while no entry is in flight.
// Reset is synchronous: it empties both registers, clears the tag history,
// and sets little endian with a file size of zero.
`include "assert_macros.svh"

module tiff_ifd_entry_checker_top
   import tiec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_head_bytes,
   input  logic [31:0] req_count_bytes,
   input  logic [31:0] req_value_bytes,
   input  logic        req_first_of_directory,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_tag,
   output logic [15:0] rsp_entry_type,
   output logic [31:0] rsp_count,
   output logic        rsp_is_reference,
   output logic [31:0] rsp_value_word,
   output logic [4:0]  rsp_table_slot,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type      cfg;
   hist_type     hist;
   hist_upd_type upd;
   result_type   res;
   logic         record;
   logic [15:0]  rec_tag;

   logic         s1_valid_ff, s1_valid_in;
   logic [31:0]  s1_head_ff, s1_count_ff, s1_value_ff;
   logic         s1_first_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_ff;
   logic         advance, req_xfer;

   tiec_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tiec_decode u_decode (
      .cfg                (cfg),
      .hist               (hist),
      .head_bytes         (s1_head_ff),
      .count_bytes        (s1_count_ff),
      .value_bytes        (s1_value_ff),
      .first_of_directory (s1_first_ff),
      .res                (res),
      .record             (record),
      .rec_tag            (rec_tag)
   );

   tiec_order_hist u_hist (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .hist  (hist)
   );

   // advance the result register when it is empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   assign upd.commit = s1_valid_ff && advance;
   assign upd.first  = s1_first_ff;
   assign upd.record = record;
   assign upd.tag    = rec_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_head_ff  <= req_head_bytes;
         s1_count_ff <= req_count_bytes;
         s1_value_ff <= req_value_bytes;
         s1_first_ff <= req_first_of_directory;
      end
      if (upd.commit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_tag          = rsp_ff.tag;
   assign rsp_entry_type   = rsp_ff.entry_type;
   assign rsp_count        = rsp_ff.count;
   assign rsp_is_reference = rsp_ff.is_reference;
   assign rsp_value_word   = rsp_ff.value_word;
   assign rsp_table_slot   = rsp_ff.table_slot;

   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall,
      s1_valid_ff && rsp_valid_ff, "input stalled while a register is free")
   `ASSERT_IMPLIES(a_ok_has_slot, clock, reset, rsp_valid_ff && rsp_ff.status == ST_OK,
      rsp_ff.table_slot != NO_SLOT, "accepted entry without a table slot")
   `ASSERT_IMPLIES(a_early_reject_clean, clock, reset,
      rsp_valid_ff && (rsp_ff.status == ST_UNSUPPORTED || rsp_ff.status == ST_ZERO_COUNT),
      !rsp_ff.is_reference && rsp_ff.value_word == 32'd0 && rsp_ff.table_slot == NO_SLOT,
      "rejected entry carries data")
   `ASSERT_NEXT(a_hist_follows_record, clock, reset, upd.commit && upd.record,
      hist.have && hist.tag == $past(upd.tag), "tag history not updated")

endmodule

// ===== hw/rtl/tiec_csr.sv =====
module tiec_csr
   import tiec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   typedef enum logic {
      REG_BIG_ENDIAN,
      REG_FILE_SIZE
   } reg_idx_type;

   logic        big_endian_ff, big_endian_in;
   logic [31:0] file_size_ff, file_size_in;
   reg_idx_type sel;
   logic        wr_en;

   assign sel    = reg_idx_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      big_endian_in = big_endian_ff;
      file_size_in  = file_size_ff;
      if (wr_en) begin
         case (sel)
            REG_BIG_ENDIAN: big_endian_in = pwdata[0];
            REG_FILE_SIZE:  file_size_in  = pwdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_BIG_ENDIAN: prdata = {31'd0, big_endian_ff};
         REG_FILE_SIZE:  prdata = file_size_ff;
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         file_size_ff  <= 32'd0;
      end else begin
         big_endian_ff <= big_endian_in;
         file_size_ff  <= file_size_in;
      end
   end

   assign cfg.big_endian = big_endian_ff;
   assign cfg.file_size  = file_size_ff;

endmodule

// ===== hw/rtl/tiec_order_hist.sv =====
module tiec_order_hist
   import tiec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hist_upd_type upd,
   output hist_type     hist
);

   logic        have_ff, have_in;
   logic [15:0] tag_ff, tag_in;

   always_comb begin
      have_in = have_ff;
      tag_in  = tag_ff;
      if (upd.commit) begin
         if (upd.record) begin
            have_in = 1'b1;
            tag_in  = upd.tag;
         end else if (upd.first) begin
            // new directory with a rejected first entry: forget the old one
            have_in = 1'b0;
            tag_in  = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         tag_ff  <= 16'd0;
      end else begin
         have_ff <= have_in;
         tag_ff  <= tag_in;
      end
   end

   assign hist.have = have_ff;
   assign hist.tag  = tag_ff;

endmodule

// ===== hw/rtl/tiec_decode.sv =====
module tiec_decode
   import tiec_pkg::*;
(
   input  cfg_type      cfg,
   input  hist_type     hist,
   input  logic [31:0]  head_bytes,
   input  logic [31:0]  count_bytes,
   input  logic [31:0]  value_bytes,
   input  logic         first_of_directory,
   output result_type   res,
   output logic         record,
   output logic [15:0]  rec_tag
);

   logic [15:0] tag, etype;
   logic [31:0] cnt, val_word, val_half, val_sel;
   logic        type_ok, cnt_zero, is_ref, past_end, out_of_order, have_eff;
   logic [1:0]  size_log2;
   logic [34:0] nbytes;
   logic [35:0] end_pos;
   logic        hit;
   logic [4:0]  hit_slot;
   logic        hit_type_ok, hit_count_one;

   assign tag   = cfg.big_endian ? swap16(head_bytes[15:0])  : head_bytes[15:0];
   assign etype = cfg.big_endian ? swap16(head_bytes[31:16]) : head_bytes[31:16];
   assign cnt   = cfg.big_endian ? swap32(count_bytes) : count_bytes;

   assign val_word = cfg.big_endian ? swap32(value_bytes) : value_bytes;
   assign val_half = cfg.big_endian ?
      {swap16(value_bytes[31:16]), swap16(value_bytes[15:0])} : value_bytes;

   assign type_ok  = (etype != 16'd0) && (etype <= TYPE_LAST);
   assign cnt_zero = (cnt == 32'd0);

   always_comb begin
      case (etype[3:0])
         4'd3, 4'd8:         size_log2 = 2'd1;
         4'd4, 4'd9, 4'd11:  size_log2 = 2'd2;
         4'd5, 4'd10, 4'd12: size_log2 = 2'd3;
         default:            size_log2 = 2'd0;
      endcase
   end

   assign nbytes = {3'd0, cnt} << size_log2;
   assign is_ref = type_ok && !cnt_zero && (nbytes > 35'd4);

   always_comb begin
      if (is_ref)
         val_sel = val_word;
      else if (etype == TYPE_SHORT || etype == TYPE_SSHORT)
         val_sel = val_half;
      else if (etype == TYPE_LONG || etype == TYPE_SLONG)
         val_sel = val_word;
      else
         val_sel = value_bytes;
   end

   assign end_pos  = {1'b0, nbytes} + {4'd0, val_word};
   assign past_end = is_ref && (end_pos > {4'd0, cfg.file_size});

   assign have_eff     = hist.have && !first_of_directory;
   assign out_of_order = have_eff && (tag <= hist.tag);

   // tags are unique, so at most one slot hits
   always_comb begin
      hit           = 1'b0;
      hit_slot      = NO_SLOT;
      hit_type_ok   = 1'b0;
      hit_count_one = 1'b0;
      for (int i = 0; i < NUM_DECLS; i++) begin
         if (DECL_TAG[i] == tag) begin
            hit           = 1'b1;
            hit_slot      = 5'(i);
            hit_type_ok   = DECL_TYPEMASK[i][etype[3:0]];
            hit_count_one = DECL_COUNT_ONE[i];
         end
      end
   end

   assign record  = type_ok && !cnt_zero && !past_end && !out_of_order;
   assign rec_tag = tag;

   always_comb begin
      res.tag          = tag;
      res.entry_type   = etype;
      res.count        = cnt;
      res.is_reference = is_ref;
      res.value_word   = val_sel;
      res.table_slot   = NO_SLOT;
      if (!type_ok) begin
         res.status     = ST_UNSUPPORTED;
         res.count      = 32'd0;
         res.value_word = 32'd0;
      end else if (cnt_zero) begin
         res.status     = ST_ZERO_COUNT;
         res.value_word = 32'd0;
      end else if (past_end) begin
         res.status = ST_PAST_END;
      end else if (out_of_order) begin
         res.status = ST_OUT_OF_ORDER;
      end else if (!hit) begin
         res.status = ST_UNKNOWN_TAG;
      end else begin
         res.table_slot = hit_slot;
         if (!hit_type_ok)
            res.status = ST_WRONG_TYPE;
         else if (hit_count_one && cnt != 32'd1)
            res.status = ST_WRONG_COUNT;
         else
            res.status = ST_OK;
      end
   end

endmodule
